// ----- rtl/rpem_pkg.sv -----
`timescale 1ns / 1ps

package rpem_pkg;

	// Geometry of the line store.
	localparam int MAX_WIDTH    = 1024;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ADDR_W       = COL_W + 1;
	localparam int STORE_DEPTH  = 2 ** ADDR_W;
	localparam int WID_W        = $clog2(MAX_WIDTH + 1);

	// Channel arithmetic.
	localparam int CHANNEL_BITS = 16;
	localparam int CHAN_W       = 16;
	localparam logic [CHAN_W-1:0] CHAN_MASK = CHAN_W'((32'd1 << CHANNEL_BITS) - 32'd1);
	localparam int SUM_W        = CHAN_W + 2;
	// floor(x / 3) = (x * GREY_RECIP) >> GREY_SHIFT for every x below 2**GREY_SHIFT.
	localparam int GREY_SHIFT   = 19;
	localparam logic [SUM_W-1:0] GREY_RECIP = SUM_W'(((32'd1 << GREY_SHIFT) + 32'd1) / 32'd3);
	localparam int PROD_W       = 2 * SUM_W;

	// Configuration port.
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int ROW_WIDTH_W  = 11;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATE_MASK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MASK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREY_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ENABLE = 3'd5;

	localparam logic [15:0]            RST_FULL_SCALE = 16'd255;
	localparam logic [ROW_WIDTH_W-1:0] RST_ROW_WIDTH  = 11'd640;

	// Request kinds carried in req_type.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// Command queue between front and back.
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic        req_type;
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic        row_end;
	} out_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [15:0]            full_scale;
		logic [ROW_WIDTH_W-1:0] row_width;
		logic [2:0]             negate_mask;
		logic [2:0]             zero_mask;
		logic                   grey_enable;
		logic                   mirror_enable;
	} cfg_t;

	// One unit of work for the back end.
	typedef struct packed {
		logic              emit;
		logic              from_store;
		logic              last;
		logic              wr;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
		pixel_t            pixel;
	} cmd_t;

endpackage

// ----- rtl/rpem_front.sv -----
`timescale 1ns / 1ps

module rpem_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rpem_pkg::in_item_t in_data,
	input  rpem_pkg::cfg_t    cfg,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output rpem_pkg::cmd_t    cmd
);

	// Negate then zero one channel.
	function automatic logic [rpem_pkg::CHAN_W-1:0] chan_fx(
		input logic [rpem_pkg::CHAN_W-1:0] v_raw,
		input logic [rpem_pkg::CHAN_W-1:0] mc,
		input logic                        neg,
		input logic                        zer
	);
		logic [rpem_pkg::CHAN_W-1:0] v;
		v = v_raw & rpem_pkg::CHAN_MASK;
		if (neg) begin
			v = (v >= mc) ? (v - mc) : (mc - v);
		end
		if (zer) begin
			v = '0;
		end
		return v;
	endfunction

	logic [rpem_pkg::COL_W-1:0]  wc_q;
	logic [rpem_pkg::COL_W-1:0]  rc_q;
	logic                        bank_q;
	logic                        pending_q;

	logic [rpem_pkg::WID_W-1:0]  eff_w;
	logic [rpem_pkg::CHAN_W-1:0] mc;
	logic                        en;
	logic                        acc;
	logic                        is_drain;
	logic [rpem_pkg::COL_W:0]    wc_inc;
	logic [rpem_pkg::COL_W:0]    rc_inc;
	logic                        wc_wrap;
	logic                        rc_last;
	logic [rpem_pkg::COL_W-1:0]  rd_col;
	logic                        has_cmd;
	rpem_pkg::cmd_t              ctl;
	rpem_pkg::pixel_t            pix_in;

	logic                        v_s1, v_s2, v_s3;
	logic                        grey_s1, grey_s2;
	rpem_pkg::cmd_t              ctl_s1, ctl_s2, cmd_s3;
	rpem_pkg::cmd_t              cmd_next;
	rpem_pkg::pixel_t            pix_s1, pix_s2;
	logic [rpem_pkg::SUM_W-1:0]  sum_s2;
	logic [rpem_pkg::PROD_W-1:0] prod;
	logic [rpem_pkg::CHAN_W-1:0] avg;

	always_comb begin
		if (cfg.row_width == '0) begin
			eff_w = rpem_pkg::WID_W'(1);
		end else if (32'(cfg.row_width) > 32'(rpem_pkg::MAX_WIDTH)) begin
			eff_w = rpem_pkg::WID_W'(rpem_pkg::MAX_WIDTH);
		end else begin
			eff_w = rpem_pkg::WID_W'(cfg.row_width);
		end
	end

	assign mc       = cfg.full_scale & rpem_pkg::CHAN_MASK;
	assign en       = !v_s3 || cmd_ready;
	assign in_ready = en;
	assign acc      = in_valid && en;
	assign is_drain = (in_data.req_type == rpem_pkg::REQ_DRAIN);

	assign wc_inc  = {1'b0, wc_q} + 1'b1;
	assign rc_inc  = {1'b0, rc_q} + 1'b1;
	assign wc_wrap = 32'(wc_inc) >= 32'(eff_w);
	assign rc_last = 32'(rc_inc) >= 32'(eff_w);
	assign rd_col  = (32'(rc_q) < 32'(eff_w))
		? rpem_pkg::COL_W'(eff_w - rpem_pkg::WID_W'(1) - rpem_pkg::WID_W'(rc_q)) : '0;

	assign pix_in.red   = chan_fx(in_data.red_in,   mc, cfg.negate_mask[0], cfg.zero_mask[0]);
	assign pix_in.green = chan_fx(in_data.green_in, mc, cfg.negate_mask[1], cfg.zero_mask[1]);
	assign pix_in.blue  = chan_fx(in_data.blue_in,  mc, cfg.negate_mask[2], cfg.zero_mask[2]);

	// Classification of the incoming request; the pixel is filled in later.
	always_comb begin
		ctl         = '0;
		ctl.rd_addr = {~bank_q, rd_col};
		ctl.wr_addr = {bank_q, wc_q};
		has_cmd     = 1'b0;
		if (is_drain) begin
			has_cmd        = pending_q;
			ctl.emit       = pending_q;
			ctl.from_store = 1'b1;
			ctl.last       = rc_last;
		end else if (!cfg.mirror_enable) begin
			has_cmd  = 1'b1;
			ctl.emit = 1'b1;
			ctl.last = wc_wrap;
		end else begin
			has_cmd        = 1'b1;
			ctl.wr         = 1'b1;
			ctl.emit       = pending_q;
			ctl.from_store = 1'b1;
			ctl.last       = rc_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q      <= '0;
			rc_q      <= '0;
			bank_q    <= 1'b0;
			pending_q <= 1'b0;
		end else if (acc) begin
			if (is_drain || cfg.mirror_enable) begin
				if (pending_q) begin
					if (rc_last) begin
						pending_q <= 1'b0;
						rc_q      <= '0;
					end else begin
						rc_q <= rc_inc[rpem_pkg::COL_W-1:0];
					end
				end
			end
			if (!is_drain) begin
				if (wc_wrap) begin
					wc_q <= '0;
					if (cfg.mirror_enable) begin
						bank_q    <= ~bank_q;
						pending_q <= 1'b1;
						rc_q      <= '0;
					end
				end else begin
					wc_q <= wc_inc[rpem_pkg::COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && has_cmd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign prod = sum_s2 * rpem_pkg::GREY_RECIP;
	assign avg  = prod[rpem_pkg::GREY_SHIFT +: rpem_pkg::CHAN_W];

	// The command of the last stage takes the greyscale pixel when it is enabled.
	always_comb begin
		cmd_next = ctl_s2;
		if (grey_s2) begin
			cmd_next.pixel = '{red: avg, green: avg, blue: avg};
		end else begin
			cmd_next.pixel = pix_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl;
			pix_s1  <= pix_in;
			grey_s1 <= cfg.grey_enable;

			ctl_s2  <= ctl_s1;
			pix_s2  <= pix_s1;
			grey_s2 <= grey_s1;
			sum_s2  <= rpem_pkg::SUM_W'(pix_s1.red) + rpem_pkg::SUM_W'(pix_s1.green)
				+ rpem_pkg::SUM_W'(pix_s1.blue);

			cmd_s3 <= cmd_next;
		end
	end

	assign cmd_valid = v_s3;
	assign cmd       = cmd_s3;

	a_idle_read_column: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (rc_q == '0))
		else $error("read column moved with no row pending");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !cmd_ready) |=> (v_s3 && $stable(cmd_s3)))
		else $error("front end lost a stalled command");

endmodule

// ----- rtl/rpem_queue.sv -----
`timescale 1ns / 1ps

module rpem_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rpem_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rpem_pkg::cmd_t pop_data
);

	rpem_pkg::cmd_t              slot_q [rpem_pkg::QUEUE_DEPTH];
	logic [rpem_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rpem_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rpem_pkg::QPTR_W:0]   count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = count_q != (rpem_pkg::QPTR_W + 1)'(rpem_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= rpem_pkg::QUEUE_DEPTH)
		else $error("command queue count beyond its depth");

endmodule

// ----- rtl/rpem_back.sv -----
`timescale 1ns / 1ps

module rpem_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  rpem_pkg::cmd_t      cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output rpem_pkg::out_item_t out_data
);

	rpem_pkg::pixel_t    store_mem [rpem_pkg::STORE_DEPTH];
	rpem_pkg::pixel_t    rdata_s1;
	rpem_pkg::pixel_t    pix_s1;
	logic                from_store_s1;
	logic                last_s1;
	logic                v_s1;
	logic                out_valid_q;
	rpem_pkg::out_item_t out_data_q;
	rpem_pkg::pixel_t    sel_pix;
	logic                adv;
	logic                pop;

	assign adv       = v_s1 && (!out_valid_q || out_ready);
	assign pop       = cmd_valid && (!v_s1 || adv);
	assign cmd_ready = !v_s1 || adv;

	// Line store: at most one write and one registered read per command.
	always_ff @(posedge clk) begin
		if (pop && cmd.wr) begin
			store_mem[cmd.wr_addr] <= cmd.pixel;
		end
		if (pop) begin
			rdata_s1 <= store_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pix_s1        <= cmd.pixel;
			from_store_s1 <= cmd.from_store;
			last_s1       <= cmd.last;
		end
	end

	assign sel_pix = from_store_s1 ? rdata_s1 : pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= cmd.emit;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.red_out   <= sel_pix.red;
			out_data_q.green_out <= sel_pix.green;
			out_data_q.blue_out  <= sel_pix.blue;
			out_data_q.row_end   <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_banks_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.wr && cmd.emit) |-> (cmd.wr_addr[rpem_pkg::COL_W] != cmd.rd_addr[rpem_pkg::COL_W]))
		else $error("store read and write hit the same bank");

	a_read_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(rdata_s1)))
		else $error("stalled store read data changed");

endmodule

// ----- rtl/rgb_pixel_effects_mirror.sv -----
`timescale 1ns / 1ps

// RGB pixel effects with optional horizontal row mirror. Each request carries
// either one pixel or a drain marker. Every channel selected in negate_mask
// becomes |value - full_scale|, then every channel selected in zero_mask is
// forced to zero, and with grey_enable all three channels take the truncated
// average of the three. With mirror_enable clear a pixel request gives its
// processed pixel at once, with row_end set on every row_width-th pixel (zero
// counts as one, over 1024 as 1024). With mirror_enable set, pixels fill one
// bank of a two-bank line store while the previous complete row is sent out
// reversed from the other bank, one pixel for each pixel request; a drain
// request sends the next pixel of a pending row without supplying one, and
// does nothing when no row is pending. A row that completes while the older
// one is still pending replaces it. The block takes one request per clock and
// gives at most one result per clock while the output does not stall. When
// nothing stalls, a taken request passes two further front stages, the
// command queue, the store read stage and the output register. The line store
// is read and written at most once per clock by the back end. Registers must
// be written only while the block is idle; the block itself does not enforce
// this. The line store holds no defined data after reset, needs no clearing
// pass, and its read data is only sent out for a pending row.
module rgb_pixel_effects_mirror (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rpem_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rpem_pkg::out_item_t                 out_data,
	input  logic                                cfg_wr_en,
	input  logic [rpem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpem_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

	rpem_pkg::cfg_t cfg_q;
	rpem_pkg::cmd_t front_cmd;
	rpem_pkg::cmd_t back_cmd;
	logic           front_valid;
	logic           front_ready;
	logic           back_valid;
	logic           back_ready;

	// Configuration registers. Writes to an index beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_scale    <= rpem_pkg::RST_FULL_SCALE;
			cfg_q.row_width     <= rpem_pkg::RST_ROW_WIDTH;
			cfg_q.negate_mask   <= '0;
			cfg_q.zero_mask     <= '0;
			cfg_q.grey_enable   <= 1'b0;
			cfg_q.mirror_enable <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rpem_pkg::REG_FULL_SCALE: begin
					cfg_q.full_scale <= cfg_wr_data[15:0];
				end
				rpem_pkg::REG_ROW_WIDTH: begin
					cfg_q.row_width <= cfg_wr_data[rpem_pkg::ROW_WIDTH_W-1:0];
				end
				rpem_pkg::REG_NEGATE_MASK: begin
					cfg_q.negate_mask <= cfg_wr_data[2:0];
				end
				rpem_pkg::REG_ZERO_MASK: begin
					cfg_q.zero_mask <= cfg_wr_data[2:0];
				end
				rpem_pkg::REG_GREY_ENABLE: begin
					cfg_q.grey_enable <= cfg_wr_data[0];
				end
				rpem_pkg::REG_MIRROR_ENABLE: begin
					cfg_q.mirror_enable <= cfg_wr_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// The front end takes requests, applies the colour effects and decides,
	// from the column counters, which store write and which output each one
	// causes. Requests that cause nothing leave no command behind.
	rpem_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// A short queue lets the front keep taking requests while the output
	// side is briefly stalled.
	rpem_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	// The back end owns the line store and the output register.
	rpem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
